[design/ffa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ffa_pkg;

  localparam int NUM_BLOCKS_DEF = 16;

  localparam int LEN_W   = 5;
  localparam int IDX_W   = 5;
  localparam int START_W = 4;

  // Per-block status mark.
  typedef enum logic [2:0] {
    MARK_FREE  = 3'd0,
    MARK_ONE   = 3'd1,
    MARK_FIRST = 3'd2,
    MARK_MID   = 3'd3,
    MARK_LAST  = 3'd4
  } mark_t;

  typedef enum logic [1:0] {
    OUT_ALLOC_OK   = 2'd0,
    OUT_ALLOC_FAIL = 2'd1,
    OUT_FREED      = 2'd2,
    OUT_IGNORED    = 2'd3
  } outcome_t;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_t;

  // Write strobe and data toward the mark store.
  typedef struct packed {
    logic  en;
    mark_t data;
  } mark_wr_t;

endpackage

`default_nettype wire

[design/ffa_mark_store.sv]
`timescale 1ns / 1ps
`default_nettype none

module ffa_mark_store #(
  parameter int NUM_BLOCKS = ffa_pkg::NUM_BLOCKS_DEF,
  parameter int IW         = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [IW-1:0]    addr,
  input  wire ffa_pkg::mark_wr_t wr,
  output ffa_pkg::mark_t        rd_data
);
  import ffa_pkg::*;

  mark_t marks_r [NUM_BLOCKS];

  // One shared port: read and write at the same address.
  assign rd_data = marks_r[addr];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        marks_r[i] <= MARK_FREE;
      end
    end else if (wr.en) begin
      marks_r[addr] <= wr.data;
    end
  end

endmodule

`default_nettype wire

[design/first_fit_block_run_allocator_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Steps: allocate scans the marks for a free run, then writes the run's marks block by block,
//   then posts the result; free clears the run block by block, then posts the result.
// Requests: one request at a time; the limit is the single read/write port on the mark
//   store, visited one block per cycle.
// Reset: synchronous, active low; all marks return to free and no result is pending.

module first_fit_block_run_allocator_core #(
  parameter int NUM_BLOCKS = ffa_pkg::NUM_BLOCKS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_req_type,
  input  wire logic [ffa_pkg::LEN_W-1:0]     in_run_length,
  input  wire logic [ffa_pkg::IDX_W-1:0]     in_block_index,
  input  wire logic                          in_id_valid,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_outcome,
  output logic [ffa_pkg::START_W-1:0]        out_start_index
);
  import ffa_pkg::*;

  localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int SW = (IW > START_W) ? IW : START_W;
  localparam logic [7:0]    NB8      = 8'(NUM_BLOCKS);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BLOCKS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_FREE_HEAD,
    S_FREE_WALK,
    S_DONE
  } state_t;

  state_t          state_r, state_nxt;
  logic [IW-1:0]   ptr_r, ptr_nxt;
  logic [IW-1:0]   start_r, start_nxt;
  logic [IW-1:0]   end_r, end_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  outcome_t        res_r, res_nxt;
  logic            out_valid_r, out_valid_nxt;
  outcome_t        out_outcome_r, out_outcome_nxt;
  logic [START_W-1:0] out_start_r, out_start_nxt;

  mark_t    rd_mark;
  mark_wr_t wr;
  logic     in_beat;
  logic     at_last;
  logic [SW-1:0] start_wide;

  ffa_mark_store #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .IW         (IW)
  ) u_marks (
    .clk     (clk),
    .rst_n   (rst_n),
    .addr    (ptr_r),
    .wr      (wr),
    .rd_data (rd_mark)
  );

  assign in_stall        = (state_r != S_IDLE);
  assign in_beat         = in_valid && !in_stall;
  assign at_last         = (ptr_r == LAST_IDX);
  assign start_wide      = SW'(start_r);
  assign out_valid       = out_valid_r;
  assign out_outcome     = out_outcome_r;
  assign out_start_index = out_start_r;

  always_comb begin
    state_nxt       = state_r;
    ptr_nxt         = ptr_r;
    start_nxt       = start_r;
    end_nxt         = end_r;
    len_nxt         = len_r;
    cnt_nxt         = cnt_r;
    res_nxt         = res_r;
    out_outcome_nxt = out_outcome_r;
    out_start_nxt   = out_start_r;
    out_valid_nxt   = out_valid_r && out_stall;
    wr.en           = 1'b0;
    wr.data         = MARK_FREE;

    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          len_nxt   = in_run_length;
          start_nxt = '0;
          cnt_nxt   = '0;
          if (in_req_type == REQ_ALLOC) begin
            ptr_nxt = '0;
            // Zero length or longer than the pool: fail without scanning.
            if (in_run_length == '0 || {3'b000, in_run_length} > NB8) begin
              res_nxt   = OUT_ALLOC_FAIL;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_SCAN;
            end
          end else begin
            if (!in_id_valid || {3'b000, in_block_index} >= NB8) begin
              ptr_nxt   = '0;
              res_nxt   = OUT_IGNORED;
              state_nxt = S_DONE;
            end else begin
              ptr_nxt   = IW'(in_block_index);
              state_nxt = S_FREE_HEAD;
            end
          end
        end
      end

      S_SCAN: begin
        // Count free blocks in a row; the first window to fill is the lowest start.
        if (rd_mark == MARK_FREE && (cnt_r + 5'd1) == len_r) begin
          end_nxt   = ptr_r;
          start_nxt = ptr_r - IW'(len_r - 5'd1);
          ptr_nxt   = ptr_r - IW'(len_r - 5'd1);
          state_nxt = S_MARK;
        end else begin
          cnt_nxt = (rd_mark == MARK_FREE) ? cnt_r + 5'd1 : '0;
          if (at_last) begin
            res_nxt   = OUT_ALLOC_FAIL;
            start_nxt = '0;
            state_nxt = S_DONE;
          end else begin
            ptr_nxt = ptr_r + 1'b1;
          end
        end
      end

      S_MARK: begin
        wr.en = 1'b1;
        priority if (len_r == 5'd1) begin
          wr.data = MARK_ONE;
        end else if (ptr_r == start_r) begin
          wr.data = MARK_FIRST;
        end else if (ptr_r == end_r) begin
          wr.data = MARK_LAST;
        end else begin
          wr.data = MARK_MID;
        end
        if (ptr_r == end_r) begin
          res_nxt   = OUT_ALLOC_OK;
          state_nxt = S_DONE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end

      S_FREE_HEAD: begin
        priority if (rd_mark == MARK_ONE) begin
          wr.en     = 1'b1;
          res_nxt   = OUT_FREED;
          state_nxt = S_DONE;
        end else if (rd_mark == MARK_FIRST) begin
          wr.en   = 1'b1;
          res_nxt = OUT_FREED;
          if (at_last) begin
            state_nxt = S_DONE;
          end else begin
            ptr_nxt   = ptr_r + 1'b1;
            state_nxt = S_FREE_WALK;
          end
        end else begin
          res_nxt   = OUT_IGNORED;
          state_nxt = S_DONE;
        end
      end

      S_FREE_WALK: begin
        // Clear middles, stop after the end mark or at any other mark.
        priority if (rd_mark == MARK_MID) begin
          wr.en = 1'b1;
          if (at_last) begin
            state_nxt = S_DONE;
          end else begin
            ptr_nxt = ptr_r + 1'b1;
          end
        end else if (rd_mark == MARK_LAST) begin
          wr.en     = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        // Hold the result until the output register is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_outcome_nxt = res_r;
          out_start_nxt   = (res_r == OUT_ALLOC_OK) ? start_wide[START_W-1:0] : '0;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ptr_r         <= ptr_nxt;
    start_r       <= start_nxt;
    end_r         <= end_nxt;
    len_r         <= len_nxt;
    cnt_r         <= cnt_nxt;
    res_r         <= res_nxt;
    out_outcome_r <= out_outcome_nxt;
    out_start_r   <= out_start_nxt;
  end

endmodule

`default_nettype wire

[design/ffa_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module ffa_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [1:0]                    out_outcome,
  input wire logic [ffa_pkg::START_W-1:0]   out_start_index
);
  import ffa_pkg::*;

  // An accepted request leaves the block busy in the following cycle.
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a request is in flight");

  // Only a successful allocate carries a start index.
  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outcome != OUT_ALLOC_OK |-> out_start_index == '0)
    else $error("nonzero start index on a non-allocate outcome");

  // Stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_outcome)
      && $stable(out_start_index))
    else $error("stalled result beat changed");

  // Reset drops any pending result.
  a_reset_clears: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind first_fit_block_run_allocator_core ffa_checker u_ffa_checker (.*);

`default_nettype wire

[sim/first_fit_block_run_allocator_core_tb.sv]
`timescale 1ns / 1ps

module first_fit_block_run_allocator_core_tb;
  import ffa_pkg::*;

  localparam int BLOCKS       = NUM_BLOCKS_DEF;
  localparam int RANDOM_ITEMS = 720;
  localparam int PHASES       = 4;
  // Room for the worst request, with long stall and idle streaks on top.
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 2 * BLOCKS + 8;
  localparam int REPORT_MAX   = 10;

  // One expected result beat.
  typedef struct packed {
    outcome_t             outcome;
    logic [START_W-1:0]   start;
  } grant_t;

  // Mirror of the block's mark table plus the queue of results still owed.
  class run_allocation_tracker;
    mark_t  marks [BLOCKS];
    grant_t pending_grants [$];
    int     failures;
    int     checked;
    int     tally [4];

    function new();
      foreach (marks[i]) marks[i] = MARK_FREE;
      foreach (tally[i]) tally[i] = 0;
      failures = 0;
      checked  = 0;
    endfunction

    // Apply one accepted request to the mirrored marks and queue its result.
    function void note_request(req_t req, logic [LEN_W-1:0] len, logic [IDX_W-1:0] idx,
                               logic id_ok);
      grant_t g;
      int     n;
      int     s;
      int     k;
      int     i;
      bit     room;
      bit     found;
      bit     walking;
      mark_t  m;
      n = len;
      g.start = '0;
      if (req == REQ_ALLOC) begin
        g.outcome = OUT_ALLOC_FAIL;
        found = 1'b0;
        if (n != 0 && n <= BLOCKS) begin
          // First fit: lowest start with n free blocks in a row.
          for (s = 0; s + n <= BLOCKS && !found; s++) begin
            room = 1'b1;
            for (k = 0; k < n; k++) begin
              if (marks[s + k] != MARK_FREE) room = 1'b0;
            end
            if (room) begin
              if (n == 1) begin
                marks[s] = MARK_ONE;
              end else begin
                marks[s] = MARK_FIRST;
                for (k = 1; k < n - 1; k++) marks[s + k] = MARK_MID;
                marks[s + n - 1] = MARK_LAST;
              end
              found     = 1'b1;
              g.outcome = OUT_ALLOC_OK;
              g.start   = START_W'(s);
            end
          end
        end
      end else begin
        g.outcome = OUT_IGNORED;
        if (id_ok && idx < BLOCKS) begin
          if (marks[idx] == MARK_ONE) begin
            marks[idx] = MARK_FREE;
            g.outcome  = OUT_FREED;
          end else if (marks[idx] == MARK_FIRST) begin
            marks[idx] = MARK_FREE;
            g.outcome  = OUT_FREED;
            // Walk the run; stop after the end mark or at anything foreign.
            i = idx + 1;
            walking = 1'b1;
            while (walking && i < BLOCKS) begin
              m = marks[i];
              if (m != MARK_MID && m != MARK_LAST) begin
                walking = 1'b0;
              end else begin
                marks[i] = MARK_FREE;
                if (m == MARK_LAST) walking = 1'b0;
                i++;
              end
            end
          end
        end
      end
      tally[g.outcome]++;
      pending_grants.push_back(g);
    endfunction

    // Compare one accepted result beat against the oldest expectation.
    function void check_grant(logic [1:0] outcome, logic [START_W-1:0] start);
      grant_t g;
      checked++;
      if (pending_grants.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("[%0t] unexpected result beat: outcome %0d start %0d", $realtime,
                   outcome, start);
      end else begin
        g = pending_grants.pop_front();
        if (outcome !== g.outcome || start !== g.start) begin
          failures++;
          if (failures <= REPORT_MAX)
            $display("[%0t] mismatch: expected outcome %0d start %0d, got outcome %0d start %0d",
                     $realtime, g.outcome, g.start, outcome, start);
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n          = 1'b0;
  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic               in_req_type    = 1'b0;
  logic [LEN_W-1:0]   in_run_length  = '0;
  logic [IDX_W-1:0]   in_block_index = '0;
  logic               in_id_valid    = 1'b0;
  logic               out_valid;
  logic               out_stall      = 1'b0;
  logic [1:0]         out_outcome;
  logic [START_W-1:0] out_start_index;

  run_allocation_tracker tracker = new;

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int sent_beats      = 0;
  int quiet_cycles    = 0;

  first_fit_block_run_allocator_core #(
    .NUM_BLOCKS(BLOCKS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_run_length   (in_run_length),
    .in_block_index  (in_block_index),
    .in_id_valid     (in_id_valid),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_outcome     (out_outcome),
    .out_start_index (out_start_index)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver side: draw a fresh stall every falling edge at the phase's rate.
  always @(negedge clk) begin
    out_stall = (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Result monitor: check every accepted result beat.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_grant(out_outcome, out_start_index);
  end

  // Watchdog: end the run if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  // Drive one request beat. Enter and leave at a falling edge; hold the payload while stalled.
  task automatic send_request(req_t req, logic [LEN_W-1:0] len, logic [IDX_W-1:0] idx,
                              logic id_ok);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_req_type    = req;
    in_run_length  = len;
    in_block_index = idx;
    in_id_valid    = id_ok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_request(req, len, idx, id_ok);
    sent_beats++;
    @(negedge clk);
  endtask

  // Drop valid and hold off until every owed result has come back.
  task automatic wait_for_grants();
    in_valid = 1'b0;
    while (tracker.pending_grants.size() != 0) @(negedge clk);
  endtask

  // One random request. Mostly well-formed allocate/free traffic against live runs,
  // with some noise (random index, bad handle, zero or oversize length) mixed in.
  task automatic random_request(output bit counted);
    int live [$];
    int used;
    int pick;
    int len;
    used = 0;
    foreach (tracker.marks[i]) begin
      if (tracker.marks[i] != MARK_FREE) used++;
      if (tracker.marks[i] == MARK_ONE || tracker.marks[i] == MARK_FIRST) live.push_back(i);
    end
    pick = $urandom_range(99);
    counted = 1'b1;
    if (pick < 12) begin
      counted = 1'b0;
      send_request(req_t'($urandom_range(1)), LEN_W'($urandom_range(31)),
                   IDX_W'($urandom_range(31)), 1'($urandom_range(1)));
    end else if (live.size() != 0 && (pick < 50 || used > 12)) begin
      send_request(REQ_FREE, LEN_W'($urandom_range(31)),
                   IDX_W'(live[$urandom_range(live.size() - 1)]), 1'b1);
    end else begin
      // Keep most runs short; now and then ask for something big.
      len = ($urandom_range(9) == 0) ? $urandom_range(BLOCKS, 1) : $urandom_range(5, 1);
      send_request(REQ_ALLOC, LEN_W'(len), IDX_W'($urandom_range(31)),
                   1'($urandom_range(1)));
    end
  endtask

  initial begin
    int  done;
    bit  counted;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: length limits, first fit, every way a free is ignored, run walks.
    send_request(REQ_ALLOC, 5'd0, 5'd0, 1'b0);                 // zero length fails
    send_request(REQ_ALLOC, LEN_W'(BLOCKS + 1), 5'd31, 1'b1);  // one past the table fails
    send_request(REQ_ALLOC, 5'd31, 5'd0, 1'b0);                // widest length fails
    send_request(REQ_ALLOC, 5'd1, 5'd0, 1'b0);                 // single at 0
    send_request(REQ_ALLOC, LEN_W'(BLOCKS), 5'd0, 1'b0);       // no room
    send_request(REQ_ALLOC, 5'd3, 5'd0, 1'b0);                 // run at 1..3
    send_request(REQ_ALLOC, 5'd2, 5'd0, 1'b0);                 // run at 4..5
    send_request(REQ_FREE, 5'd0, 5'd2, 1'b1);                  // run middle: ignored
    send_request(REQ_FREE, 5'd0, 5'd3, 1'b1);                  // run end: ignored
    send_request(REQ_FREE, 5'd0, 5'd10, 1'b1);                 // free block: ignored
    send_request(REQ_FREE, 5'd31, 5'd0, 1'b0);                 // bad handle: ignored
    send_request(REQ_FREE, 5'd0, IDX_W'(BLOCKS), 1'b1);        // index past the table: ignored
    send_request(REQ_FREE, 5'd0, 5'd31, 1'b1);                 // widest index: ignored
    send_request(REQ_FREE, 5'd0, 5'd1, 1'b1);                  // walk 1..3, stop at the end mark
    send_request(REQ_FREE, 5'd0, 5'd0, 1'b1);                  // single
    send_request(REQ_ALLOC, 5'd2, 5'd0, 1'b0);                 // lands at 0 again, below 4..5
    send_request(REQ_FREE, 5'd0, 5'd0, 1'b1);                  // must not touch 4..5
    send_request(REQ_ALLOC, 5'd1, 5'd0, 1'b0);                 // lands at 0
    send_request(REQ_FREE, 5'd0, 5'd4, 1'b1);
    send_request(REQ_FREE, 5'd0, 5'd0, 1'b1);
    send_request(REQ_ALLOC, LEN_W'(BLOCKS), 5'd0, 1'b1);       // whole table
    send_request(REQ_FREE, 5'd0, 5'd0, 1'b1);                  // walk to the last block
    send_request(REQ_ALLOC, LEN_W'(BLOCKS - 1), 5'd0, 1'b0);
    send_request(REQ_ALLOC, 5'd1, 5'd0, 1'b0);                 // fills the last block
    send_request(REQ_ALLOC, 5'd1, 5'd0, 1'b0);                 // full: fails
    send_request(REQ_FREE, 5'd0, IDX_W'(BLOCKS - 1), 1'b1);
    send_request(REQ_FREE, 5'd0, 5'd0, 1'b1);
    wait_for_grants();

    // Random part across idle/stall phases; pause for all results at each phase end.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin sender_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      done = 0;
      while (done < RANDOM_ITEMS / PHASES) begin
        random_request(counted);
        if (counted) done++;
      end
      wait_for_grants();
    end

    // Let the block settle and watch for stray result beats.
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d requests over %0d idle/stall phases: %0d granted, %0d refused",
             sent_beats, PHASES, tracker.tally[OUT_ALLOC_OK], tracker.tally[OUT_ALLOC_FAIL]);
    $display("frees: %0d released, %0d ignored; %0d result beats checked, %0d failures",
             tracker.tally[OUT_FREED], tracker.tally[OUT_IGNORED], tracker.checked,
             tracker.failures);
    if (tracker.failures == 0 && tracker.pending_grants.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
